### rtl/core/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Shared codes, default sizes and controller/datapath interface types for the
// segmented memory manager.
// ----------------------------------------------------------------------------
package smm_pkg;

	localparam int unsigned NUM_SEGMENTS_DEF  = 256;
	localparam int unsigned SEGMENT_WORDS_DEF = 1024;

	localparam int KIND_W   = 3;
	localparam int SEG_ID_W = 8;
	localparam int OFF_W    = 10;
	localparam int WORD_W   = 32;
	localparam int CNT_W    = 11;
	localparam int STATUS_W = 3;

	localparam logic [KIND_W-1:0] K_FETCH   = 3'd0;
	localparam logic [KIND_W-1:0] K_MAP     = 3'd1;
	localparam logic [KIND_W-1:0] K_UNMAP   = 3'd2;
	localparam logic [KIND_W-1:0] K_LOAD    = 3'd3;
	localparam logic [KIND_W-1:0] K_STORE   = 3'd4;
	localparam logic [KIND_W-1:0] K_LOADPRG = 3'd5;
	localparam logic [KIND_W-1:0] K_APPEND  = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_ID     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNMAPPED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

	// What the datapath asks the controller to do after evaluating an item.
	typedef enum logic [1:0] {
		ACT_DONE,
		ACT_READ,
		ACT_ZERO,
		ACT_COPY
	} smm_act_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic take_read;
		logic zero_step;
		logic copy_read;
		logic copy_write;
		logic finish;
	} smm_cmd_t;

	typedef struct packed {
		smm_act_t act;
		logic     walk_last;
	} smm_sts_t;

endpackage

### rtl/core/segmented_memory_manager.sv
// ----------------------------------------------------------------------------
// segmented_memory_manager
// Segmented word memory with a program counter over segment zero.
// ----------------------------------------------------------------------------
// Steps: fetch and load go through evaluation, a word read and finish; store,
//   unmap, append and refused items through evaluation and finish; map clears
//   word_count words, load program reads and writes each source segment word.
// Throughput: one item at a time; the next input transfer is taken in the cycle
//   after the result is placed in the output register (single word store port).
// Reset: arst_n clears control state at once; only segment zero is mapped,
//   with length zero; no clearing pass runs.
module segmented_memory_manager import smm_pkg::*; #(
	parameter int unsigned NUM_SEGMENTS  = NUM_SEGMENTS_DEF,
	parameter int unsigned SEGMENT_WORDS = SEGMENT_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [SEG_ID_W-1:0] segment_id,
	input  logic [OFF_W-1:0]    word_offset,
	input  logic [WORD_W-1:0]   word_value,
	input  logic [CNT_W-1:0]    word_count,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [WORD_W-1:0]   read_data,
	output logic [SEG_ID_W-1:0] mapped_id,
	output logic                more_instructions,
	output logic [STATUS_W-1:0] status
);

	// The controller issues at most one command per cycle; the datapath answers with
	// the action an item needs after evaluation and the end of a word walk.
	smm_cmd_t cmd;
	smm_sts_t sts;

	smm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the word store, the length table, the free queue
	// and the result register, which lets a finished transfer wait on the
	// output side while the controller returns to idle.
	smm_dp #(
		.NUM_SEGMENTS  (NUM_SEGMENTS),
		.SEGMENT_WORDS (SEGMENT_WORDS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.kind              (kind),
		.segment_id        (segment_id),
		.word_offset       (word_offset),
		.word_value        (word_value),
		.word_count        (word_count),
		.read_data         (read_data),
		.mapped_id         (mapped_id),
		.more_instructions (more_instructions),
		.status            (status)
	);

endmodule

### rtl/core/smm_dp.sv
// ----------------------------------------------------------------------------
// smm_dp
// Datapath: word store, segment tables, free identifier queue, program
// counter and the result register.
// ----------------------------------------------------------------------------
module smm_dp import smm_pkg::*; #(
	parameter int unsigned NUM_SEGMENTS  = NUM_SEGMENTS_DEF,
	parameter int unsigned SEGMENT_WORDS = SEGMENT_WORDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smm_cmd_t             cmd,
	output smm_sts_t             sts,
	input  logic [KIND_W-1:0]    kind,
	input  logic [SEG_ID_W-1:0]  segment_id,
	input  logic [OFF_W-1:0]     word_offset,
	input  logic [WORD_W-1:0]    word_value,
	input  logic [CNT_W-1:0]     word_count,
	output logic [WORD_W-1:0]    read_data,
	output logic [SEG_ID_W-1:0]  mapped_id,
	output logic                 more_instructions,
	output logic [STATUS_W-1:0]  status
);

	localparam longint unsigned DEPTH = longint'(NUM_SEGMENTS) * longint'(SEGMENT_WORDS);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SEG_W  = $clog2(NUM_SEGMENTS);
	localparam int LEN_W  = $clog2(SEGMENT_WORDS + 1);
	localparam int PC_W   = (LEN_W > OFF_W) ? LEN_W : OFF_W;

	logic [WORD_W-1:0] word_mem [DEPTH];
	logic [LEN_W-1:0]  len_mem  [NUM_SEGMENTS];
	logic [SEG_W-1:0]  fq_mem   [NUM_SEGMENTS];

	// Control state
	logic [NUM_SEGMENTS-1:0] mapped_q;
	logic [SEG_W-1:0]        head_q, tail_q;
	logic [SEG_W:0]          free_cnt_q, used_q;
	logic [PC_W-1:0]         pc_q;
	logic [LEN_W-1:0]        len0_q;
	logic [LEN_W-1:0]        ptr_q, walk_len_q;

	// Item and result payload
	logic [KIND_W-1:0]   kind_q;
	logic [SEG_ID_W-1:0] seg_q;
	logic [OFF_W-1:0]    off_q;
	logic [WORD_W-1:0]   val_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [WORD_W-1:0]   rd_q;
	logic [SEG_ID_W-1:0] nseg_q;
	logic [STATUS_W-1:0] st_q;
	logic [ADDR_W-1:0]   base_q;
	logic [LEN_W-1:0]    len_rd_q;
	logic [SEG_W-1:0]    fq_rd_q;
	logic [WORD_W-1:0]   mem_rd_q;

	logic [SEG_W-1:0]    seg_idx;
	logic                seg_ok;
	logic [LEN_W-1:0]    seg_len;
	logic [ADDR_W-1:0]   seg_base, id_base;

	smm_act_t            ev_act;
	logic [STATUS_W-1:0] ev_st;
	logic                ev_we;
	logic [ADDR_W-1:0]   ev_waddr, ev_raddr;
	logic [SEG_W-1:0]    map_id;
	logic                map_ok, map_pop, map_bump, unmap_ok, prog_copy, prog_set;
	logic                append_ok;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
	logic [WORD_W-1:0]   mem_wdata;

	assign seg_idx  = SEG_W'(seg_q);
	assign seg_ok   = (seg_q < NUM_SEGMENTS) && mapped_q[seg_idx];
	// Segment zero keeps its length in a register of its own.
	assign seg_len  = (seg_q == '0) ? len0_q : len_rd_q;
	assign seg_base = ADDR_W'(seg_idx) * ADDR_W'(SEGMENT_WORDS);
	assign id_base  = ADDR_W'(map_id) * ADDR_W'(SEGMENT_WORDS);

	always_comb begin
		ev_act    = ACT_DONE;
		ev_st     = ST_OK;
		ev_we     = 1'b0;
		ev_waddr  = seg_base + ADDR_W'(off_q);
		ev_raddr  = seg_base + ADDR_W'(off_q);
		map_id    = '0;
		map_ok    = 1'b0;
		map_pop   = 1'b0;
		map_bump  = 1'b0;
		unmap_ok  = 1'b0;
		prog_copy = 1'b0;
		prog_set  = 1'b0;
		append_ok = 1'b0;
		case (kind_q)
			K_FETCH: begin
				if (pc_q < len0_q) begin
					ev_act   = ACT_READ;
					ev_raddr = ADDR_W'(pc_q);
				end else begin
					ev_st = ST_RANGE;
				end
			end
			K_MAP: begin
				if (cnt_q > SEGMENT_WORDS) begin
					ev_st = ST_TOO_LARGE;
				end else if (free_cnt_q != '0) begin
					map_ok  = 1'b1;
					map_pop = 1'b1;
					map_id  = fq_rd_q;
				end else if (used_q < NUM_SEGMENTS) begin
					map_ok   = 1'b1;
					map_bump = 1'b1;
					map_id   = SEG_W'(used_q);
				end else begin
					ev_st = ST_NO_ID;
				end
				if (map_ok && cnt_q != '0) begin
					ev_act = ACT_ZERO;
				end
			end
			K_UNMAP: begin
				if (seg_q == '0 || !seg_ok || free_cnt_q >= NUM_SEGMENTS) begin
					ev_st = ST_UNMAPPED;
				end else begin
					unmap_ok = 1'b1;
				end
			end
			K_LOAD: begin
				if (!seg_ok) begin
					ev_st = ST_UNMAPPED;
				end else if (off_q >= seg_len) begin
					ev_st = ST_RANGE;
				end else begin
					ev_act = ACT_READ;
				end
			end
			K_STORE: begin
				if (!seg_ok) begin
					ev_st = ST_UNMAPPED;
				end else if (off_q >= seg_len) begin
					ev_st = ST_RANGE;
				end else begin
					ev_we = 1'b1;
				end
			end
			K_LOADPRG: begin
				if (seg_q == '0) begin
					prog_set = 1'b1;
				end else if (!seg_ok) begin
					ev_st = ST_UNMAPPED;
				end else begin
					prog_set  = 1'b1;
					prog_copy = 1'b1;
					if (len_rd_q != '0) begin
						ev_act = ACT_COPY;
					end
				end
			end
			K_APPEND: begin
				if (len0_q >= SEGMENT_WORDS) begin
					ev_st = ST_RANGE;
				end else begin
					append_ok = 1'b1;
					ev_we     = 1'b1;
					ev_waddr  = ADDR_W'(len0_q);
				end
			end
			default: begin
				ev_st = ST_OK;
			end
		endcase
	end

	assign sts.act       = ev_act;
	assign sts.walk_last = ((ptr_q + 1'b1) == walk_len_q);

	// Word store port selection.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ev_waddr;
		mem_wdata = val_q;
		mem_raddr = ev_raddr;
		if (cmd.eval) begin
			mem_we = ev_we;
		end else if (cmd.zero_step) begin
			mem_we    = 1'b1;
			mem_waddr = base_q + ADDR_W'(ptr_q);
			mem_wdata = '0;
		end else if (cmd.copy_read) begin
			mem_raddr = base_q + ADDR_W'(ptr_q);
		end else if (cmd.copy_write) begin
			mem_we    = 1'b1;
			mem_waddr = ADDR_W'(ptr_q);
			mem_wdata = mem_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			word_mem[mem_waddr] <= mem_wdata;
		end
		mem_rd_q <= word_mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.eval && map_ok) begin
			len_mem[map_id] <= LEN_W'(cnt_q);
		end
		len_rd_q <= len_mem[SEG_W'(segment_id)];
	end

	always_ff @(posedge clk) begin
		if (cmd.eval && unmap_ok) begin
			fq_mem[tail_q] <= seg_idx;
		end
		fq_rd_q <= fq_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapped_q   <= NUM_SEGMENTS'(1);
			head_q     <= '0;
			tail_q     <= '0;
			free_cnt_q <= '0;
			used_q     <= (SEG_W+1)'(1);
			pc_q       <= '0;
			len0_q     <= '0;
			ptr_q      <= '0;
			walk_len_q <= '0;
		end else begin
			if (cmd.eval) begin
				ptr_q <= '0;
				if (map_ok) begin
					mapped_q[map_id] <= 1'b1;
					walk_len_q       <= LEN_W'(cnt_q);
				end
				if (map_pop) begin
					head_q     <= (head_q == SEG_W'(NUM_SEGMENTS - 1)) ? '0 : head_q + 1'b1;
					free_cnt_q <= free_cnt_q - 1'b1;
				end
				if (map_bump) begin
					used_q <= used_q + 1'b1;
				end
				if (unmap_ok) begin
					mapped_q[seg_idx] <= 1'b0;
					tail_q     <= (tail_q == SEG_W'(NUM_SEGMENTS - 1)) ? '0 : tail_q + 1'b1;
					free_cnt_q <= free_cnt_q + 1'b1;
				end
				if (prog_copy) begin
					len0_q     <= len_rd_q;
					walk_len_q <= len_rd_q;
				end
				if (prog_set) begin
					pc_q <= PC_W'(off_q);
				end
				if (append_ok) begin
					len0_q <= len0_q + 1'b1;
				end
			end
			if (cmd.take_read && kind_q == K_FETCH) begin
				pc_q <= pc_q + 1'b1;
			end
			if (cmd.zero_step || cmd.copy_write) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			seg_q  <= segment_id;
			off_q  <= word_offset;
			val_q  <= word_value;
			cnt_q  <= word_count;
			rd_q   <= '0;
			nseg_q <= '0;
		end
		if (cmd.eval) begin
			st_q <= ev_st;
			if (map_ok) begin
				nseg_q <= SEG_ID_W'(map_id);
				base_q <= id_base;
			end else begin
				base_q <= seg_base;
			end
		end
		if (cmd.take_read) begin
			rd_q <= mem_rd_q;
		end
		if (cmd.finish) begin
			read_data         <= rd_q;
			mapped_id         <= nseg_q;
			status            <= st_q;
			more_instructions <= (pc_q < len0_q);
		end
	end

endmodule

### rtl/core/smm_ctrl.sv
// ----------------------------------------------------------------------------
// smm_ctrl
// Controller: sequences one item through evaluation, word reads, slot
// clearing and program copy, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module smm_ctrl import smm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output smm_cmd_t cmd,
	input  smm_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_READ,
		S_ZERO,
		S_CPRD,
		S_CPWR,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == S_IDLE) && in_valid;
		cmd.eval       = (state_q == S_EVAL);
		cmd.take_read  = (state_q == S_READ);
		cmd.zero_step  = (state_q == S_ZERO);
		cmd.copy_read  = (state_q == S_CPRD);
		cmd.copy_write = (state_q == S_CPWR);
		cmd.finish     = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace one that is taken in the same cycle.
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					case (sts.act)
						ACT_READ: state_q <= S_READ;
						ACT_ZERO: state_q <= S_ZERO;
						ACT_COPY: state_q <= S_CPRD;
						default:  state_q <= S_DONE;
					endcase
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_ZERO: begin
					if (sts.walk_last) begin
						state_q <= S_DONE;
					end
				end
				S_CPRD: begin
					state_q <= S_CPWR;
				end
				S_CPWR: begin
					state_q <= sts.walk_last ? S_DONE : S_CPRD;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result appeared without a finished item");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> (state_q == S_DONE))
		else $error("finished item dropped while result register busy");

	a_zero_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ZERO && sts.walk_last) |=> (state_q == S_DONE))
		else $error("slot clearing ran past its count");

	a_copy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CPWR && !sts.walk_last) |=> (state_q == S_CPRD))
		else $error("program copy stopped early");

endmodule

### bench/segmented_memory_manager_tb.sv
// ----------------------------------------------------------------------------
// segmented_memory_manager_tb
// Drives requests into the segmented memory manager, predicts every response
// from a behavioral copy of the segment store, and compares each field.
// ----------------------------------------------------------------------------
module segmented_memory_manager_tb import smm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSEG  = NUM_SEGMENTS_DEF;
	localparam int SWORD = SEGMENT_WORDS_DEF;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SEG_ID_W-1:0] seg;
		logic [OFF_W-1:0]    off;
		logic [WORD_W-1:0]   val;
		logic [CNT_W-1:0]    cnt;
	} request_t;

	typedef struct packed {
		logic [WORD_W-1:0]   rd;
		logic [SEG_ID_W-1:0] nseg;
		logic                more;
		logic [STATUS_W-1:0] st;
	} response_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [KIND_W-1:0] kind;
	logic [SEG_ID_W-1:0] segment_id;
	logic [OFF_W-1:0] word_offset;
	logic [WORD_W-1:0] word_value;
	logic [CNT_W-1:0] word_count;
	logic [WORD_W-1:0] read_data;
	logic [SEG_ID_W-1:0] mapped_id;
	logic more_instructions;
	logic [STATUS_W-1:0] status;

	segmented_memory_manager dut (.*);

	// Behavioral model of the memory.
	logic [WORD_W-1:0] mem_words [NSEG*SWORD];
	int unsigned seg_len [NSEG];
	bit seg_live [NSEG];
	int unsigned id_fifo [NSEG];
	int unsigned fifo_head, fifo_tail, fifo_count, ids_used, pc;

	request_t  pending_reqs[$];
	response_t expected_resp[$];
	int errors, sent, received;
	int send_idle_pct, recv_stall_pct;
	int kind_seen [8];

	// Tracks which segments the generator believes mapped, for well-formed traffic.
	bit gen_live [NSEG];

	function automatic response_t predict_access(request_t r);
		response_t o;
		int unsigned s, base;
		o = '0;
		s = r.seg;
		case (r.kind)
			K_FETCH: begin
				if (pc < seg_len[0]) begin
					o.rd = mem_words[pc];
					pc++;
				end else o.st = ST_RANGE;
			end
			K_MAP: begin
				int unsigned id;
				if (r.cnt > SWORD) o.st = ST_TOO_LARGE;
				else if (fifo_count == 0 && ids_used >= NSEG) o.st = ST_NO_ID;
				else begin
					if (fifo_count > 0) begin
						id = id_fifo[fifo_head];
						fifo_head = (fifo_head + 1) % NSEG;
						fifo_count--;
					end else begin
						id = ids_used;
						ids_used++;
					end
					for (int i = 0; i < r.cnt; i++) mem_words[id*SWORD + i] = '0;
					seg_len[id] = r.cnt;
					seg_live[id] = 1;
					o.nseg = SEG_ID_W'(id);
				end
			end
			K_UNMAP: begin
				if (s == 0 || !seg_live[s] || fifo_count >= NSEG) o.st = ST_UNMAPPED;
				else begin
					seg_live[s] = 0;
					seg_len[s] = 0;
					id_fifo[fifo_tail] = s;
					fifo_tail = (fifo_tail + 1) % NSEG;
					fifo_count++;
				end
			end
			K_LOAD, K_STORE: begin
				base = s * SWORD;
				if (!seg_live[s]) o.st = ST_UNMAPPED;
				else if (r.off >= seg_len[s]) o.st = ST_RANGE;
				else if (r.kind == K_LOAD) o.rd = mem_words[base + r.off];
				else mem_words[base + r.off] = r.val;
			end
			K_LOADPRG: begin
				if (s != 0 && !seg_live[s]) o.st = ST_UNMAPPED;
				else begin
					if (s != 0) begin
						for (int i = 0; i < seg_len[s]; i++)
							mem_words[i] = mem_words[s*SWORD + i];
						seg_len[0] = seg_len[s];
					end
					pc = r.off;
				end
			end
			K_APPEND: begin
				if (seg_len[0] >= SWORD) o.st = ST_RANGE;
				else begin
					mem_words[seg_len[0]] = r.val;
					seg_len[0]++;
				end
			end
			default: ;
		endcase
		o.more = (pc < seg_len[0]);
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH response %0d %s: got %0h want %0h", received, what, got, want);
		errors++;
	endtask

	function automatic request_t make_req(int k, int s, int o, logic [31:0] v, int c);
		request_t r;
		r.kind = KIND_W'(k);
		r.seg = SEG_ID_W'(s);
		r.off = OFF_W'(o);
		r.val = v;
		r.cnt = CNT_W'(c);
		return r;
	endfunction

	// Picks a segment the generator believes mapped, or noise now and then.
	function automatic int pick_seg();
		int s;
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
		for (int t = 0; t < 20; t++) begin
			s = $urandom_range(0, 15);
			if (gen_live[s]) return s;
		end
		return 0;
	endfunction

	task automatic queue_req(request_t r);
		pending_reqs.push_back(r);
	endtask

	task automatic build_random(int n);
		request_t r;
		int pick, s, c;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			s = pick_seg();
			r = make_req(0, s, $urandom_range(0, 1023), $urandom(), 0);
			if (pick < 18) begin
				r.kind = K_MAP;
				c = $urandom_range(0, 19) == 0 ? $urandom_range(0, 2047)
					: $urandom_range(0, 12);
				r.cnt = CNT_W'(c);
			end else if (pick < 26) r.kind = K_UNMAP;
			else if (pick < 42) r.kind = K_LOAD;
			else if (pick < 60) r.kind = K_STORE;
			else if (pick < 66) r.kind = K_LOADPRG;
			else if (pick < 78) r.kind = K_APPEND;
			else if (pick < 98) r.kind = K_FETCH;
			else r.kind = 3'd7;
			// Offsets mostly land inside the small segments that are mapped.
			if (r.kind != K_LOADPRG && $urandom_range(0, 3) != 0)
				r.off = OFF_W'($urandom_range(0, 12));
			if (r.kind == K_LOADPRG && $urandom_range(0, 3) != 0)
				r.off = OFF_W'($urandom_range(0, 4));
			if (r.kind == K_UNMAP && s < NSEG) gen_live[s] = 0;
			if (r.kind == K_MAP) begin
				for (int j = 1; j < 16; j++) if (!gen_live[j]) begin
					gen_live[j] = 1;
					break;
				end
			end
			queue_req(r);
		end
	endtask

	task automatic wait_drain();
		while (pending_reqs.size() != 0 || expected_resp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Clock.
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Driver: the request is presented from the head of the queue and popped on
	// each accepted transfer; the prediction is made at the same moment.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			kind <= '0; segment_id <= '0; word_offset <= '0; word_value <= '0;
			word_count <= '0;
		end else begin
			request_t r;
			logic take_new;
			take_new = !in_valid;
			if (in_valid && !in_stall) begin
				r = pending_reqs.pop_front();
				expected_resp.push_back(predict_access(r));
				kind_seen[r.kind]++;
				sent++;
				take_new = 1;
			end
			if (take_new) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					r = pending_reqs[0];
					in_valid <= 1;
					kind <= r.kind; segment_id <= r.seg; word_offset <= r.off;
					word_value <= r.val; word_count <= r.cnt;
				end else in_valid <= 0;
			end
		end
	end

	// Monitor: compares every accepted response and randomizes the stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_stall <= 0;
		else begin
			response_t w;
			if (out_valid && !out_stall) begin
				if (expected_resp.size() == 0) begin
					report_mismatch("response with nothing expected", '0, '0);
				end else begin
					w = expected_resp.pop_front();
					if (read_data !== w.rd) report_mismatch("read_data", read_data, w.rd);
					if (mapped_id !== w.nseg)
						report_mismatch("mapped_id", mapped_id, w.nseg);
					if (more_instructions !== w.more)
						report_mismatch("more_instructions", more_instructions, w.more);
					if (status !== w.st) report_mismatch("status", status, w.st);
				end
				received++;
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Stimulus sequence.
	initial begin
		arst_n = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < NSEG; i++) begin
			seg_len[i] = 0;
			seg_live[i] = (i == 0);
			gen_live[i] = (i == 0);
		end
		fifo_head = 0; fifo_tail = 0; fifo_count = 0; ids_used = 1; pc = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// Directed: fetch past the end of an empty program, append, fetch.
		queue_req(make_req(K_FETCH, 0, 0, 0, 0));
		queue_req(make_req(K_APPEND, 0, 0, 32'hFFFF_FFFF, 0));
		queue_req(make_req(K_APPEND, 0, 0, 32'h0000_0000, 0));
		queue_req(make_req(K_FETCH, 0, 0, 0, 0));
		// Map with the largest count, a count too large, and an empty segment.
		queue_req(make_req(K_MAP, 0, 0, 0, SWORD));
		queue_req(make_req(K_MAP, 0, 0, 0, 2047));
		queue_req(make_req(K_MAP, 0, 0, 0, 0));
		queue_req(make_req(K_STORE, 1, 1023, 32'hA5A5_5A5A, 0));
		queue_req(make_req(K_LOAD, 1, 1023, 0, 0));
		queue_req(make_req(K_LOAD, 1, 0, 0, 0));
		queue_req(make_req(K_STORE, 2, 0, 32'h1, 0));
		queue_req(make_req(K_LOAD, 255, 0, 0, 0));
		queue_req(make_req(K_STORE, 200, 0, 0, 0));
		// Unmapping segment zero and an unmapped one are refused.
		queue_req(make_req(K_UNMAP, 0, 0, 0, 0));
		queue_req(make_req(K_UNMAP, 9, 0, 0, 0));
		queue_req(make_req(K_LOADPRG, 1, 1023, 0, 0));
		queue_req(make_req(K_FETCH, 0, 0, 0, 0));
		queue_req(make_req(K_LOADPRG, 0, 1000, 0, 0));
		queue_req(make_req(K_LOADPRG, 77, 0, 0, 0));
		queue_req(make_req(K_UNMAP, 2, 0, 0, 0));
		queue_req(make_req(K_UNMAP, 1, 0, 0, 0));
		// Freed identifiers come back first-freed-first-reused.
		queue_req(make_req(K_MAP, 0, 0, 0, 3));
		queue_req(make_req(K_MAP, 0, 0, 0, 2));
		queue_req(make_req(K_MAP, 0, 0, 0, 1));
		queue_req(make_req(7, 255, 1023, 32'hFFFF_FFFF, 2047));
		for (int i = 1; i <= 3; i++) gen_live[i] = 1;
		wait_drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			build_random(140);
			wait_drain();
		end

		// Exhaust identifiers, then fill segment zero to its limit by a copy.
		send_idle_pct = 0; recv_stall_pct = 0;
		for (int i = 0; i < NSEG + 2; i++) queue_req(make_req(K_MAP, 0, 0, 0, 0));
		queue_req(make_req(K_UNMAP, 5, 0, 0, 0));
		queue_req(make_req(K_MAP, 0, 0, 0, SWORD));
		queue_req(make_req(K_MAP, 0, 0, 0, 4));
		queue_req(make_req(K_LOADPRG, 5, 1022, 0, 0));
		for (int i = 0; i < 2; i++) queue_req(make_req(K_APPEND, 0, 0, $urandom(), 0));
		for (int i = 0; i < 3; i++) queue_req(make_req(K_FETCH, 0, 0, 0, 0));
		wait_drain();

		$display("Covered %0d transfers in, %0d out: fetch %0d map %0d unmap %0d", sent,
			received, kind_seen[0], kind_seen[1], kind_seen[2]);
		$display("load %0d store %0d load-program %0d append %0d unknown %0d",
			kind_seen[3], kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
		if (errors == 0 && expected_resp.size() == 0)
			$display("segmented_memory_manager_tb: done, clean");
		else
			$display("segmented_memory_manager_tb: done, errors");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#250ms;
		$display("segmented_memory_manager_tb: done, errors");
		$finish;
	end

endmodule
